// ===== src/gtc_pkg.sv =====
// Shared types and constants for the grinder timer controller.
// No dependencies; compile first.
`default_nettype none

package gtc_pkg;

  localparam int DEB_W      = 10;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int ADC_W      = 8;
  localparam int STATE_W    = 2;
  localparam int DUTY_W     = 11;
  localparam int COUNT_W    = 11;
  localparam int MOD_W      = 8;

  localparam int DUTY_FULL    = 1999;
  localparam int DUTY_LOW     = 50;
  localparam int FADE_SPAN    = 1949;
  localparam int FADE_PERIOD  = 200;
  localparam int FADE_STEP_Q  = FADE_SPAN / FADE_PERIOD;
  localparam int FADE_STEP_R  = FADE_SPAN % FADE_PERIOD;
  localparam int GRIND_BASE   = 500;
  localparam int GRIND_SCALE  = 1000;

  localparam int DEBOUNCE_RST = 100;
  localparam int TIMEOUT_RST  = 1999;

  // Configuration register indexes
  typedef enum logic {
    CFG_DEBOUNCE = 1'b0,
    CFG_TIMEOUT  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ARMED  = 2'd1,
    PH_LOCKED = 2'd2
  } phase_t;

  typedef enum logic [STATE_W-1:0] {
    ST_STOP  = 2'd0,
    ST_RUN   = 2'd1,
    ST_PAUSE = 2'd2
  } run_t;

  // pause_mod, fade_q and fade_rem track pause_count % 200 and the
  // quotient/remainder of (pause_count % 200) * 1949 / 200.
  typedef struct packed {
    phase_t               phase;
    logic [COUNT_W-1:0]   lock_count;
    run_t                 run;
    logic [COUNT_W-1:0]   grind_count;
    logic [TIMEOUT_W-1:0] pause_count;
    logic [MOD_W-1:0]     pause_mod;
    logic [COUNT_W-1:0]   fade_q;
    logic [MOD_W-1:0]     fade_rem;
    logic                 fade_rising;
    logic [DUTY_W-1:0]    duty;
    logic                 tone;
  } gtc_state_t;

  typedef struct packed {
    logic [DEB_W-1:0]     lock_ticks;
    logic [TIMEOUT_W-1:0] pause_timeout;
  } gtc_cfg_t;

endpackage

`default_nettype wire

// ===== src/gtc_if.sv =====
// Handshake channels of the grinder timer controller: tick input and result.
// Depends on gtc_pkg.
`default_nettype none

interface gtc_in_if import gtc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             button_edge;
  logic             button_level;
  logic [ADC_W-1:0] adc_setting;

  modport source (output valid, button_edge, button_level, adc_setting, input ready);
  modport sink   (input valid, button_edge, button_level, adc_setting, output ready);
endinterface

interface gtc_out_if import gtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] run_state;
  logic [DUTY_W-1:0]  pwm_duty;
  logic               sound_on;
  logic               press_seen;

  modport source (output valid, run_state, pwm_duty, sound_on, press_seen, input ready);
  modport sink   (input valid, run_state, pwm_duty, sound_on, press_seen, output ready);
endinterface

`default_nettype wire

// ===== src/grinder_timer_controller.sv =====
// Grinder timer controller top level: state and config registers, handshake.
// Depends on gtc_pkg, gtc_if (gtc_in_if, gtc_out_if) and gtc_step.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------
//   in_ch    | in  | button_edge, button_level, adc_setting (one tick)
//   out_ch   | out | run_state, pwm_duty, sound_on, press_seen
//   cfg_*    | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One tick per cycle unless out_ch stalls: the whole tick update is one
// combinational pass from the accepted input into state and result registers.
// The result appears the cycle after the transfer; a new tick is taken in the
// same cycle the previous result is taken, or whenever the result slot is empty.
// Reset (synchronous, rst_n low) puts the machine in stop, debounce idle,
// counters and duty at zero, and the registers at 100 and 1999.
`default_nettype none

module grinder_timer_controller import gtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gtc_in_if.sink                in_ch,
  gtc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  gtc_state_t state_r;
  gtc_state_t state_nxt;
  gtc_cfg_t   cfg_r;
  logic       press_nxt;
  logic       press_r;
  logic       out_valid_r;
  logic       in_xfer;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_xfer     = in_ch.valid & in_ch.ready;

  gtc_step u_step (
    .cur          (state_r),
    .cfg          (cfg_r),
    .button_edge  (in_ch.button_edge),
    .button_level (in_ch.button_level),
    .adc_setting  (in_ch.adc_setting),
    .nxt          (state_nxt),
    .press        (press_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_ticks    <= DEB_W'(DEBOUNCE_RST);
      cfg_r.pause_timeout <= TIMEOUT_W'(TIMEOUT_RST);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DEBOUNCE: cfg_r.lock_ticks    <= cfg_wdata[DEB_W-1:0];
        CFG_TIMEOUT:  cfg_r.pause_timeout <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // State only moves on a transfer, so it holds the pending result while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_IDLE;
      state_r.lock_count  <= '0;
      state_r.run         <= ST_STOP;
      state_r.grind_count <= '0;
      state_r.pause_count <= '0;
      state_r.pause_mod   <= '0;
      state_r.fade_q      <= '0;
      state_r.fade_rem    <= '0;
      state_r.fade_rising <= 1'b0;
      state_r.duty        <= '0;
      state_r.tone        <= 1'b0;
      press_r             <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
        press_r <= press_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.run_state  = STATE_W'(state_r.run);
  assign out_ch.pwm_duty   = state_r.duty;
  assign out_ch.sound_on   = state_r.tone;
  assign out_ch.press_seen = press_r;

`ifndef SYNTHESIS
  a_tone_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.tone == (state_r.run == ST_RUN))
    else $error("tone state disagrees with run state");

  a_press_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && press_nxt) |=> (state_r.phase == PH_LOCKED && press_r))
    else $error("press did not lock the button");

  a_fade_track_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.pause_mod < MOD_W'(FADE_PERIOD)) && (state_r.fade_rem < MOD_W'(FADE_PERIOD)))
    else $error("fade tracking counters out of range");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(state_r))
    else $error("state moved without a transfer");
`endif

endmodule

`default_nettype wire

// ===== src/gtc_step.sv =====
// Next-state logic for one tick: debounce, stop/run/pause machine, pause fade.
// Depends on gtc_pkg.
`default_nettype none

module gtc_step import gtc_pkg::*; (
  input  gtc_state_t       cur,
  input  gtc_cfg_t         cfg,
  input  logic             button_edge,
  input  logic             button_level,
  input  logic [ADC_W-1:0] adc_setting,
  output gtc_state_t       nxt,
  output logic             press
);

  logic [17:0]          scaled;
  logic [COUNT_W-1:0]   duration;
  logic [COUNT_W-1:0]   grind_inc;
  phase_t               phase;
  logic [TIMEOUT_W-1:0] base_pc;
  logic [MOD_W-1:0]     base_mod;
  logic [COUNT_W-1:0]   base_q;
  logic [MOD_W-1:0]     base_rem;
  logic [TIMEOUT_W-1:0] pc1;
  logic [MOD_W-1:0]     mod1;
  logic [COUNT_W-1:0]   q1;
  logic [MOD_W-1:0]     rem1;
  logic [MOD_W:0]       rem_sum;

  assign scaled   = (18'({adc_setting}) + 18'd1) * 18'(GRIND_SCALE);
  assign duration = COUNT_W'(GRIND_BASE) + {1'b0, scaled[17:8]};
  assign grind_inc = cur.grind_count + 1'b1;

  // Pause counter advance; a resume press restarts it from zero first
  always_comb begin
    base_pc  = press ? '0 : cur.pause_count;
    base_mod = press ? '0 : cur.pause_mod;
    base_q   = press ? '0 : cur.fade_q;
    base_rem = press ? '0 : cur.fade_rem;
    pc1      = base_pc + 1'b1;
    rem_sum  = {1'b0, base_rem} + (MOD_W+1)'(FADE_STEP_R);
    if (base_mod == MOD_W'(FADE_PERIOD - 1) || pc1 == '0) begin
      mod1 = '0;
      q1   = '0;
      rem1 = '0;
    end else begin
      mod1 = base_mod + 1'b1;
      if (rem_sum >= (MOD_W+1)'(FADE_PERIOD)) begin
        rem1 = MOD_W'(rem_sum - (MOD_W+1)'(FADE_PERIOD));
        q1   = base_q + COUNT_W'(FADE_STEP_Q + 1);
      end else begin
        rem1 = rem_sum[MOD_W-1:0];
        q1   = base_q + COUNT_W'(FADE_STEP_Q);
      end
    end
  end

  always_comb begin
    nxt   = cur;
    press = 1'b0;

    // Debounce: an edge arms first, so edge and level on one tick give a press
    phase = cur.phase;
    if (button_edge && phase == PH_IDLE) begin
      phase = PH_ARMED;
    end
    nxt.phase = phase;
    case (phase)
      PH_ARMED: begin
        if (button_level) begin
          press     = 1'b1;
          nxt.phase = PH_LOCKED;
        end
      end
      PH_LOCKED: begin
        if (cur.lock_count > {1'b0, cfg.lock_ticks}) begin
          nxt.phase      = PH_IDLE;
          nxt.lock_count = '0;
        end else begin
          nxt.lock_count = cur.lock_count + 1'b1;
        end
      end
      default: ;
    endcase

    case (cur.run)
      ST_STOP: begin
        if (press) begin
          nxt.run  = ST_RUN;
          nxt.tone = 1'b1;
          nxt.duty = DUTY_W'(DUTY_FULL);
        end
        nxt.pause_count = '0;
        nxt.pause_mod   = '0;
        nxt.fade_q      = '0;
        nxt.fade_rem    = '0;
        nxt.grind_count = '0;
      end
      ST_RUN: begin
        if (press) begin
          nxt.run         = ST_PAUSE;
          nxt.tone        = 1'b0;
          nxt.duty        = DUTY_W'(DUTY_LOW);
          nxt.fade_rising = 1'b0;
        end
        nxt.grind_count = grind_inc;
        // Run end wins over a pause press
        if (grind_inc >= duration) begin
          nxt.grind_count = '0;
          nxt.run         = ST_STOP;
          nxt.tone        = 1'b0;
          nxt.duty        = '0;
        end
      end
      ST_PAUSE: begin
        if (press) begin
          nxt.run  = ST_RUN;
          nxt.tone = 1'b1;
        end
        nxt.pause_count = pc1;
        nxt.pause_mod   = mod1;
        nxt.fade_q      = q1;
        nxt.fade_rem    = rem1;
        if (pc1 == cfg.pause_timeout) begin
          nxt.pause_count = '0;
          nxt.pause_mod   = '0;
          nxt.fade_q      = '0;
          nxt.fade_rem    = '0;
          nxt.run         = ST_STOP;
          nxt.tone        = 1'b0;
        end
        // Flip the fade at each period start, then write the fade value
        if (nxt.pause_mod == '0) begin
          nxt.fade_rising = ~cur.fade_rising;
        end
        if (nxt.fade_rising) begin
          nxt.duty = DUTY_W'(DUTY_LOW) + nxt.fade_q;
        end else begin
          nxt.duty = DUTY_W'(DUTY_FULL) - nxt.fade_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for grinder_timer_controller: drives ticks and register
// writes, predicts every result in a scoreboard class and compares it.
// Depends on gtc_pkg, gtc_in_if / gtc_out_if and the controller RTL.

module tb import gtc_pkg::*;;

  typedef struct packed {
    logic             btn_edge;
    logic             btn_level;
    logic [ADC_W-1:0] adc;
  } tick_in_t;

  typedef struct packed {
    logic [STATE_W-1:0] run_state;
    logic [DUTY_W-1:0]  pwm_duty;
    logic               sound_on;
    logic               press_seen;
  } tick_out_t;

  localparam int PHASES = 5;
  localparam int DEB_SET [PHASES] = '{100, 0, 1023, 3, 0};
  localparam int TMO_SET [PHASES] = '{1999, 1, 65535, 250, 65535};
  localparam int LEN_SET [PHASES] = '{200, 100, 150, 300, 300};

  class tick_predictor;
    logic [DEB_W-1:0]     lock_limit;
    logic [TIMEOUT_W-1:0] pause_limit;
    phase_t               phase;
    logic [COUNT_W-1:0]   lock_cnt;
    run_t                 mstate;
    logic [COUNT_W-1:0]   grind_cnt;
    logic [TIMEOUT_W-1:0] pause_cnt;
    logic                 fade_up;
    logic [DUTY_W-1:0]    duty;
    logic                 tone;
    tick_out_t            expected_q[$];
    int                   errors;

    function new();
      lock_limit  = DEB_W'(DEBOUNCE_RST);
      pause_limit = TIMEOUT_W'(TIMEOUT_RST);
      phase       = PH_IDLE;
      lock_cnt    = '0;
      mstate      = ST_STOP;
      grind_cnt   = '0;
      pause_cnt   = '0;
      fade_up     = 1'b0;
      duty        = '0;
      tone        = 1'b0;
      errors      = 0;
    endfunction

    static function int grind_ticks(logic [ADC_W-1:0] adc);
      return GRIND_BASE + ((int'(adc) + 1) * GRIND_SCALE) / (1 << ADC_W);
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_DEBOUNCE) begin
        lock_limit = value[DEB_W-1:0];
      end else begin
        pause_limit = value[TIMEOUT_W-1:0];
      end
    endfunction

    function void take_tick(tick_in_t t);
      int   r;
      logic pressed;
      run_t nxt;
      pressed = 1'b0;
      nxt = mstate;
      if (t.btn_edge && phase == PH_IDLE) phase = PH_ARMED;
      if (phase == PH_ARMED) begin
        if (t.btn_level) begin
          pressed = 1'b1;
          phase = PH_LOCKED;
        end
      end else if (phase == PH_LOCKED) begin
        if (lock_cnt > COUNT_W'(lock_limit)) begin
          phase = PH_IDLE;
          lock_cnt = '0;
        end else begin
          lock_cnt = lock_cnt + 1'b1;
        end
      end
      case (mstate)
        ST_STOP: begin
          if (pressed) begin
            nxt = ST_RUN;
            tone = 1'b1;
            duty = DUTY_W'(DUTY_FULL);
          end
          pause_cnt = '0;
          grind_cnt = '0;
        end
        ST_RUN: begin
          if (pressed) begin
            nxt = ST_PAUSE;
            tone = 1'b0;
            duty = DUTY_W'(DUTY_LOW);
            fade_up = 1'b0;
          end
          grind_cnt = grind_cnt + 1'b1;
          // end of run overrides a press on the same tick
          if (int'(grind_cnt) >= grind_ticks(t.adc)) begin
            grind_cnt = '0;
            nxt = ST_STOP;
            tone = 1'b0;
            duty = '0;
          end
        end
        default: begin
          if (pressed) begin
            nxt = ST_RUN;
            pause_cnt = '0;
            tone = 1'b1;
            duty = DUTY_W'(DUTY_FULL);
          end
          pause_cnt = pause_cnt + 1'b1;
          if (pause_cnt == pause_limit) begin
            pause_cnt = '0;
            nxt = ST_STOP;
            tone = 1'b0;
            duty = '0;
          end
          // fade overwrites the duty on every pause tick, exits included
          r = int'(pause_cnt) % FADE_PERIOD;
          if (r == 0) fade_up = !fade_up;
          if (fade_up) begin
            duty = DUTY_W'(DUTY_LOW + (r * FADE_SPAN) / FADE_PERIOD);
          end else begin
            duty = DUTY_W'(DUTY_FULL - (r * FADE_SPAN) / FADE_PERIOD);
          end
        end
      endcase
      mstate = nxt;
      expected_q.push_back('{mstate, duty, tone, pressed});
    endfunction

    function void check_output(tick_out_t got);
      tick_out_t exp_out;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: state %0d duty %0d sound %0b press %0b",
                 $time, got.run_state, got.pwm_duty, got.sound_on, got.press_seen);
        return;
      end
      exp_out = expected_q.pop_front();
      if (got.run_state !== exp_out.run_state) begin
        errors++;
        $display("%0t: run_state expected %0d actual %0d",
                 $time, exp_out.run_state, got.run_state);
      end
      if (got.pwm_duty !== exp_out.pwm_duty) begin
        errors++;
        $display("%0t: pwm_duty expected %0d actual %0d",
                 $time, exp_out.pwm_duty, got.pwm_duty);
      end
      if (got.sound_on !== exp_out.sound_on) begin
        errors++;
        $display("%0t: sound_on expected %0b actual %0b",
                 $time, exp_out.sound_on, got.sound_on);
      end
      if (got.press_seen !== exp_out.press_seen) begin
        errors++;
        $display("%0t: press_seen expected %0b actual %0b",
                 $time, exp_out.press_seen, got.press_seen);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gtc_in_if  in_ch ();
  gtc_out_if out_ch ();

  grinder_timer_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tick_predictor    sb;
  int unsigned      tx_count = 0;
  int unsigned      rx_count = 24;
  logic [ADC_W-1:0] run_adc = '0;
  bit               end_press_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // alternate stretches of random waits with stretches of none
  function automatic int draw_wait(int unsigned count);
    return ((count / 48) % 2 == 1) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic tick_in_t make_tick();
    tick_in_t         t;
    bit               want;
    logic [ADC_W-1:0] adc;
    adc = run_adc;
    want = 1'b0;
    case (sb.mstate)
      ST_STOP: begin
        want = ($urandom_range(0, 5) == 0);
        adc = ADC_W'($urandom_range(0, 255));
        // mostly short grinds so runs finish within the item budget
        run_adc = ($urandom_range(0, 3) == 0) ? ADC_W'($urandom_range(0, 255))
                                              : ADC_W'($urandom_range(0, 15));
      end
      ST_RUN: begin
        if ($urandom_range(0, 29) == 0) adc = ADC_W'($urandom_range(0, 255));
        if (int'(sb.grind_cnt) + 1 >= sb.grind_ticks(adc)) begin
          // aim a press at the tick the run ends, surely the first time
          want = !end_press_done || ($urandom_range(0, 1) == 1);
          if (want && sb.phase != PH_LOCKED) end_press_done = 1'b1;
        end else begin
          want = ($urandom_range(0, 149) == 0);
        end
      end
      default: begin
        want = ($urandom_range(0, 99) == 0);
        adc = ADC_W'($urandom_range(0, 255));
      end
    endcase
    t.adc = adc;
    case (sb.phase)
      PH_IDLE: begin
        t.btn_edge = want || ($urandom_range(0, 5) == 0);
        if (want) begin
          t.btn_level = ($urandom_range(0, 3) != 0);
        end else begin
          t.btn_level = !t.btn_edge && ($urandom_range(0, 1) == 1);
        end
      end
      PH_ARMED: begin
        t.btn_edge = 1'($urandom_range(0, 1));
        t.btn_level = want;
      end
      default: begin
        t.btn_edge = 1'($urandom_range(0, 1));
        t.btn_level = 1'($urandom_range(0, 1));
      end
    endcase
    if ($urandom_range(0, 19) == 0) begin
      t.btn_edge = 1'($urandom_range(0, 1));
      t.btn_level = 1'($urandom_range(0, 1));
    end
    return t;
  endfunction

  task automatic send_tick(input tick_in_t t);
    int gap;
    gap = draw_wait(tx_count);
    tx_count++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.button_edge  <= t.btn_edge;
    in_ch.button_level <= t.btn_level;
    in_ch.adc_setting  <= t.adc;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_tick(t);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input int deb, input int tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= CFG_DATA_W'(deb);
    @(posedge clk);
    sb.write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(tmo);
    @(posedge clk);
    sb.write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    cfg_we <= 1'b0;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      stall = draw_wait(rx_count);
      rx_count++;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_output('{out_ch.run_state, out_ch.pwm_duty, out_ch.sound_on,
                        out_ch.press_seen});
    end
  end

  initial begin
    sb = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.button_edge  <= 1'b0;
    in_ch.button_level <= 1'b0;
    in_ch.adc_setting  <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_DEBOUNCE;
    cfg_wdata          <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: level without an edge, arm, press, edge while locked
    send_tick('{1'b0, 1'b1, 8'h00});
    send_tick('{1'b1, 1'b0, 8'hff});
    send_tick('{1'b0, 1'b1, 8'h55});
    send_tick('{1'b1, 1'b1, 8'haa});
    send_tick('{1'b0, 1'b0, 8'hff});
    settle();
    // shrinking the interval mid-lock releases the button on the next tick
    write_regs(0, 3);
    send_tick('{1'b0, 1'b0, 8'h00});
    send_tick('{1'b1, 1'b1, 8'h00});
    send_tick('{1'b0, 1'b0, 8'h00});
    send_tick('{1'b1, 1'b0, 8'h00});
    send_tick('{1'b0, 1'b0, 8'h00});
    send_tick('{1'b1, 1'b1, 8'hff});
    send_tick('{1'b0, 1'b0, 8'hff});
    send_tick('{1'b0, 1'b0, 8'h00});
    send_tick('{1'b1, 1'b1, 8'h80});
    send_tick('{1'b0, 1'b0, 8'h01});
    send_tick('{1'b0, 1'b0, 8'h7f});
    send_tick('{1'b1, 1'b1, 8'h00});
    send_tick('{1'b0, 1'b1, 8'h00});
    send_tick('{1'b0, 1'b0, 8'h00});
    send_tick('{1'b1, 1'b1, 8'hff});

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_regs(DEB_SET[p], TMO_SET[p]);
      for (int n = 0; n < LEN_SET[p]; n++) send_tick(make_tick());
    end
    settle();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
